// ===== rtl/core/amr_rtp_payload_header_packetizer_macros.svh =====
// Assertion helpers shared by the packetizer RTL.
// Both expect clk and arst_n in scope at the point of use.
`ifndef AMR_RTP_PAYLOAD_HEADER_PACKETIZER_MACROS_SVH
`define AMR_RTP_PAYLOAD_HEADER_PACKETIZER_MACROS_SVH

// Same-cycle implication
`define AMRPK_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define AMRPK_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/amrpk_pkg.sv =====
`timescale 1ns / 1ps

package amrpk_pkg;

	// Default store depth
	localparam int MAX_FRAMES_DEF = 16;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] REG_FPP      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NO_DATA  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SID      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPF      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WIDEBAND = 3'd4;

	// Register reset values
	localparam logic [4:0] FPP_RST     = 5'd1;
	localparam logic [3:0] NO_DATA_RST = 4'hF;
	localparam logic [3:0] SID_RST     = 4'd8;
	localparam logic [9:0] SPF_RST     = 10'd160;

	// Header bytes
	localparam int TOC_W = 8;
	localparam logic [TOC_W-1:0] CMR_BYTE   = 8'hF0;
	localparam logic [TOC_W-1:0] FOLLOW_SET = 8'h80;
	localparam logic [TOC_W-1:0] FOLLOW_CLR = 8'h7F;

	localparam int SIZE_W = 6;

	// Octet-aligned frame data bytes per frame type
	function automatic logic [SIZE_W-1:0] frame_size(input logic wb, input logic [3:0] ft);
		logic [SIZE_W-1:0] sz;
		sz = '0;
		if (wb) begin
			case (ft)
				4'd0: sz = 6'd17;
				4'd1: sz = 6'd23;
				4'd2: sz = 6'd32;
				4'd3: sz = 6'd36;
				4'd4: sz = 6'd40;
				4'd5: sz = 6'd46;
				4'd6: sz = 6'd50;
				4'd7: sz = 6'd58;
				4'd8: sz = 6'd60;
				4'd9: sz = 6'd5;
				default: sz = '0;
			endcase
		end else begin
			case (ft)
				4'd0: sz = 6'd12;
				4'd1: sz = 6'd13;
				4'd2: sz = 6'd15;
				4'd3: sz = 6'd17;
				4'd4: sz = 6'd19;
				4'd5: sz = 6'd20;
				4'd6: sz = 6'd26;
				4'd7: sz = 6'd31;
				4'd8: sz = 6'd5;
				default: sz = '0;
			endcase
		end
		return sz;
	endfunction

endpackage

// ===== rtl/core/amrpk_toc_ram.sv =====
`timescale 1ns / 1ps

// TOC byte store: one write port, one registered read port
module amrpk_toc_ram #(
	parameter int DEPTH = amrpk_pkg::MAX_FRAMES_DEF
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
	input  logic [amrpk_pkg::TOC_W-1:0]                wdata,
	input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
	output logic [amrpk_pkg::TOC_W-1:0]                rdata
);

	logic [amrpk_pkg::TOC_W-1:0] mem [DEPTH];
	logic [amrpk_pkg::TOC_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/amr_rtp_payload_header_packetizer.sv =====
// Octet-aligned AMR / AMR-WB RTP payload header packetizer. Each request
// carries one frame's TOC byte (command 0) or a flush (command 1). An item
// that does not close a packet leaves the input ready for the next one. An
// item that closes a packet of n frames is followed by the arithmetic states
// (two subtract steps, then the one 32x10 multiplier used twice for timestamp
// increment and time delta) and then n+1 header bytes, one header byte per
// cycle while out_stall is low, paced by the single read port of the TOC
// store. in_stall is high from the closing item until the last header byte
// is taken. The TOC store needs no clearing after reset; configuration
// writes take effect at once and belong in idle time.
`timescale 1ns / 1ps
`include "amr_rtp_payload_header_packetizer_macros.svh"

module amr_rtp_payload_header_packetizer #(
	parameter int MAX_FRAMES = amrpk_pkg::MAX_FRAMES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic [amrpk_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [amrpk_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                command,
	input  logic [7:0]                          toc,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [7:0]                          header_byte,
	output logic                                is_last,
	output logic [4:0]                          frame_count,
	output logic [9:0]                          packet_length,
	output logic [31:0]                         timestamp_increment,
	output logic [31:0]                         time_delta,
	output logic [31:0]                         frame_total,
	output logic [31:0]                         packet_total,
	output logic [31:0]                         payload_total
);

	localparam int HELD_W = $clog2(MAX_FRAMES + 1);
	localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int EW     = (HELD_W > 5) ? HELD_W : 5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_SUB,
		ST_MUL_TS,
		ST_MUL_TD,
		ST_EMIT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [4:0]  fpp_q;
	logic [3:0]  nd_q;
	logic [3:0]  sid_q;
	logic [9:0]  spf_q;
	logic        wb_q;

	// packet and running state
	logic [HELD_W-1:0] held_q;
	logic [9:0]        dh_q;
	logic [31:0]       fs_q;
	logic [31:0]       ls_q;
	logic [31:0]       lfs_q;
	logic [31:0]       pk_q;
	logic [31:0]       tot_q;

	// close sequence
	logic [HELD_W-1:0] n_q;
	logic [HELD_W-1:0] k_q;
	logic [9:0]        len_q;
	logic [31:0]       op_q;
	logic [31:0]       d2_q;
	logic [31:0]       ts_q;
	logic [31:0]       td_q;
	logic [7:0]        hdr_q;
	logic              last_q;

	// request decode
	logic                        in_acc;
	logic                        out_acc;
	logic [3:0]                  ftype;
	logic                        is_nd;
	logic                        is_sid;
	logic                        store_en;
	logic [HELD_W-1:0]           held_inc;
	logic [amrpk_pkg::SIZE_W-1:0] fsize;
	logic [EW-1:0]               fpp_ext;
	logic [EW-1:0]               max_ext;
	logic [EW-1:0]               eff_fpp;
	logic                        close_req;

	assign in_acc   = in_valid & ~in_stall;
	assign out_acc  = out_valid & ~out_stall;
	assign ftype    = toc[6:3];
	assign is_nd    = (ftype == nd_q);
	assign is_sid   = (ftype == sid_q);
	assign store_en = in_acc & ~command & ~is_nd;
	assign held_inc = held_q + HELD_W'(1);
	assign fsize    = amrpk_pkg::frame_size(wb_q, ftype);

	// effective packet size: zero acts as one, clamp to store depth
	assign fpp_ext = EW'(fpp_q);
	assign max_ext = EW'(MAX_FRAMES);
	always_comb begin
		if (fpp_ext == '0) begin
			eff_fpp = EW'(1);
		end else if (fpp_ext > max_ext) begin
			eff_fpp = max_ext;
		end else begin
			eff_fpp = fpp_ext;
		end
	end

	// does this request close the open packet
	always_comb begin
		close_req = 1'b0;
		if (command) begin
			close_req = (held_q != '0);
		end else if (is_nd) begin
			close_req = (held_q != '0);
		end else begin
			close_req = is_sid || (EW'(held_inc) >= eff_fpp);
		end
	end

	// shared multiplier: timestamp increment, then time delta
	logic [31:0] mul_a;
	logic [41:0] mul_p;
	assign mul_a = (state_q == ST_MUL_TS) ? op_q : d2_q;
	assign mul_p = mul_a * spf_q;

	// TOC store, read address runs one ahead on an accepted byte
	logic [HELD_W-1:0] k_nx;
	logic [IDX_W-1:0]  rd_addr;
	logic [7:0]        rd_data;

	assign k_nx    = k_q + HELD_W'(1);
	assign rd_addr = (out_acc) ? k_nx[IDX_W-1:0] : k_q[IDX_W-1:0];

	amrpk_toc_ram #(
		.DEPTH (MAX_FRAMES)
	) u_toc_ram (
		.clk   (clk),
		.we    (store_en),
		.waddr (held_q[IDX_W-1:0]),
		.wdata (toc),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// sequencer, counters and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fpp_q   <= amrpk_pkg::FPP_RST;
			nd_q    <= amrpk_pkg::NO_DATA_RST;
			sid_q   <= amrpk_pkg::SID_RST;
			spf_q   <= amrpk_pkg::SPF_RST;
			wb_q    <= 1'b0;
			held_q  <= '0;
			dh_q    <= '0;
			fs_q    <= '0;
			ls_q    <= '0;
			lfs_q   <= '0;
			pk_q    <= '0;
			tot_q   <= '0;
			n_q     <= '0;
			k_q     <= '0;
			last_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					amrpk_pkg::REG_FPP:      fpp_q <= cfg_data[4:0];
					amrpk_pkg::REG_NO_DATA:  nd_q  <= cfg_data[3:0];
					amrpk_pkg::REG_SID:      sid_q <= cfg_data[3:0];
					amrpk_pkg::REG_SPF:      spf_q <= cfg_data[9:0];
					amrpk_pkg::REG_WIDEBAND: wb_q  <= cfg_data[0];
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (!command) begin
							fs_q <= fs_q + 32'd1;
						end
						if (store_en) begin
							if (held_q == '0) begin
								pk_q <= pk_q + 32'd1;
							end
							held_q <= held_inc;
							dh_q   <= dh_q + 10'(fsize);
							tot_q  <= tot_q + 32'(fsize);
						end
						if (close_req) begin
							state_q <= ST_DIFF;
						end
					end
				end
				// snapshot the packet, clear the open-packet state
				ST_DIFF: begin
					n_q     <= held_q;
					k_q     <= '0;
					held_q  <= '0;
					dh_q    <= '0;
					lfs_q   <= fs_q;
					state_q <= ST_SUB;
				end
				ST_SUB: begin
					ls_q    <= op_q;
					state_q <= ST_MUL_TS;
				end
				ST_MUL_TS: begin
					state_q <= ST_MUL_TD;
				end
				ST_MUL_TD: begin
					last_q  <= (n_q == '0);
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_acc) begin
						if (last_q) begin
							last_q  <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							k_q    <= k_nx;
							last_q <= (k_nx == n_q);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_DIFF: begin
				op_q  <= fs_q - 32'(held_q);
				d2_q  <= fs_q - lfs_q;
				len_q <= 10'd1 + 10'(held_q) + dh_q;
			end
			ST_SUB: begin
				op_q <= op_q - ls_q;
			end
			ST_MUL_TS: begin
				ts_q <= mul_p[31:0];
			end
			ST_MUL_TD: begin
				td_q  <= mul_p[31:0];
				hdr_q <= amrpk_pkg::CMR_BYTE;
			end
			ST_EMIT: begin
				if (out_acc && !last_q) begin
					if (k_nx == n_q) begin
						hdr_q <= rd_data & amrpk_pkg::FOLLOW_CLR;
					end else begin
						hdr_q <= rd_data | amrpk_pkg::FOLLOW_SET;
					end
				end
			end
			default: ;
		endcase
	end

	// outputs; frame count on every byte, rest of the packet summary only on the last byte
	assign in_stall            = (state_q != ST_IDLE);
	assign out_valid           = (state_q == ST_EMIT);
	assign header_byte         = hdr_q;
	assign is_last             = last_q;
	assign frame_count         = 5'(n_q);
	assign packet_length       = last_q ? len_q : '0;
	assign timestamp_increment = last_q ? ts_q : '0;
	assign time_delta          = last_q ? td_q : '0;
	assign frame_total         = last_q ? fs_q : '0;
	assign packet_total        = last_q ? pk_q : '0;
	assign payload_total       = last_q ? tot_q : '0;

	// checks
	`AMRPK_ASSERT_IMP(a_ready_no_result, !in_stall, !out_valid, "ready while a result is pending")
	`AMRPK_ASSERT_IMP(a_held_bound, 1'b1, held_q <= HELD_W'(MAX_FRAMES), "frames held beyond store depth")
	`AMRPK_ASSERT_IMP(a_cmr_first, out_valid && (k_q == '0), header_byte == amrpk_pkg::CMR_BYTE, "first header byte is not CMR")
	`AMRPK_ASSERT_IMP(a_last_index, out_valid && is_last, (k_q == n_q) && (n_q != '0), "last byte at wrong index")
	`AMRPK_ASSERT_NXT(a_ready_after_last, out_valid && !out_stall && is_last, !in_stall, "not ready after packet end")

endmodule

// ===== sim/amrpk_header_checker.sv =====
`timescale 1ns / 1ps

package amrpk_tb_pkg;

	// Request commands
	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// Index with no register behind it, writes are dropped
	localparam logic [amrpk_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	// One header byte with its packet summary
	typedef struct packed {
		logic [7:0]  header_byte;
		logic        is_last;
		logic [4:0]  frame_count;
		logic [9:0]  packet_length;
		logic [31:0] timestamp_increment;
		logic [31:0] time_delta;
		logic [31:0] frame_total;
		logic [31:0] packet_total;
		logic [31:0] payload_total;
	} header_item_t;

endpackage

module amrpk_header_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [amrpk_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [amrpk_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic                             command,
	input  logic [7:0]                       toc,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic [7:0]                       header_byte,
	input  logic                             is_last,
	input  logic [4:0]                       frame_count,
	input  logic [9:0]                       packet_length,
	input  logic [31:0]                      timestamp_increment,
	input  logic [31:0]                      time_delta,
	input  logic [31:0]                      frame_total,
	input  logic [31:0]                      packet_total,
	input  logic [31:0]                      payload_total,
	output int                               errors,
	output int                               pending
);

	localparam int STORE_DEPTH = 16;

	// Frame data bytes per frame type, type 0 in the low slot
	localparam logic [16*6-1:0] NB_BYTES = {
		6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd5,
		6'd31, 6'd26, 6'd20, 6'd19, 6'd17, 6'd15, 6'd13, 6'd12};
	localparam logic [16*6-1:0] WB_BYTES = {
		6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd5, 6'd60,
		6'd58, 6'd50, 6'd46, 6'd40, 6'd36, 6'd32, 6'd23, 6'd17};

	// Local copy of the registers
	logic [4:0] fpp_reg;
	logic [3:0] no_data_reg;
	logic [3:0] sid_reg;
	logic [9:0] spf_reg;
	logic       wb_reg;

	// Packet being gathered and running totals
	logic [7:0]  toc_store [STORE_DEPTH];
	logic [4:0]  frames_held;
	logic [9:0]  data_bytes_held;
	logic [31:0] frames_seen;
	logic [31:0] last_sent_frame;
	logic [31:0] last_frames_seen;
	logic [31:0] packets_started;
	logic [31:0] data_bytes_total;

	amrpk_tb_pkg::header_item_t expected_headers[$];

	initial errors = 0;

	// Zero acts as one, anything above the store depth as the depth
	function automatic logic [4:0] packet_limit();
		if (fpp_reg == 5'd0)
			return 5'd1;
		if (fpp_reg > 5'(STORE_DEPTH))
			return 5'(STORE_DEPTH);
		return fpp_reg;
	endfunction

	// Queue CMR, then the held TOC bytes; frame count rides on each, the rest of the summary on the last one
	task automatic close_packet();
		amrpk_tb_pkg::header_item_t item;
		logic [4:0]   n;
		logic [31:0]  span;
		n = frames_held;
		span = frames_seen - {27'd0, n} - last_sent_frame;
		for (int k = 0; k <= int'(n); k++) begin
			item = '0;
			if (k == 0)
				item.header_byte = amrpk_pkg::CMR_BYTE;
			else if (k < int'(n))
				item.header_byte = toc_store[k-1] | amrpk_pkg::FOLLOW_SET;
			else
				item.header_byte = toc_store[k-1] & amrpk_pkg::FOLLOW_CLR;
			item.is_last = (k == int'(n));
			item.frame_count = n;
			if (k == int'(n)) begin
				item.packet_length = 10'd1 + {5'd0, n} + data_bytes_held;
				item.timestamp_increment = span * {22'd0, spf_reg};
				item.time_delta = (frames_seen - last_frames_seen) * {22'd0, spf_reg};
				item.frame_total = frames_seen;
				item.packet_total = packets_started;
				item.payload_total = data_bytes_total;
			end
			expected_headers.push_back(item);
		end
		last_sent_frame = frames_seen - {27'd0, n};
		last_frames_seen = frames_seen;
		frames_held = '0;
		data_bytes_held = '0;
	endtask

	// Apply one accepted request to the packet state
	task automatic take_request(input logic cmd, input logic [7:0] tocb);
		logic [3:0] ftype;
		logic [5:0] nbytes;
		logic       closed;
		ftype = tocb[6:3];
		closed = 1'b0;
		if (cmd == amrpk_tb_pkg::CMD_FLUSH) begin
			if (frames_held != 0)
				close_packet();
		end else begin
			frames_seen = frames_seen + 1;
			if (ftype != no_data_reg) begin
				if (frames_held == 0)
					packets_started = packets_started + 1;
				nbytes = wb_reg ? WB_BYTES[ftype*6 +: 6] : NB_BYTES[ftype*6 +: 6];
				toc_store[frames_held[3:0]] = tocb;
				data_bytes_held = data_bytes_held + {4'd0, nbytes};
				data_bytes_total = data_bytes_total + {26'd0, nbytes};
				frames_held = frames_held + 1;
				if (ftype == sid_reg) begin
					close_packet();
					closed = 1'b1;
				end
			end else if (frames_held != 0) begin
				// no-data ends the open packet
				close_packet();
				closed = 1'b1;
			end
			if (!closed && frames_held >= packet_limit())
				close_packet();
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic check_header();
		amrpk_tb_pkg::header_item_t want;
		if (expected_headers.size() == 0) begin
			$display("%0t: header byte %0h with none expected", $time, header_byte);
			errors++;
		end else begin
			want = expected_headers.pop_front();
			check_field("header_byte", 32'(want.header_byte), 32'(header_byte));
			check_field("is_last", 32'(want.is_last), 32'(is_last));
			check_field("frame_count", 32'(want.frame_count), 32'(frame_count));
			check_field("packet_length", 32'(want.packet_length), 32'(packet_length));
			check_field("timestamp_increment", want.timestamp_increment, timestamp_increment);
			check_field("time_delta", want.time_delta, time_delta);
			check_field("frame_total", want.frame_total, frame_total);
			check_field("packet_total", want.packet_total, packet_total);
			check_field("payload_total", want.payload_total, payload_total);
		end
	endtask

	// Watch config writes and both channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fpp_reg = amrpk_pkg::FPP_RST;
			no_data_reg = amrpk_pkg::NO_DATA_RST;
			sid_reg = amrpk_pkg::SID_RST;
			spf_reg = amrpk_pkg::SPF_RST;
			wb_reg = 1'b0;
			frames_held = '0;
			data_bytes_held = '0;
			frames_seen = '0;
			last_sent_frame = '0;
			last_frames_seen = '0;
			packets_started = '0;
			data_bytes_total = '0;
			expected_headers.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					amrpk_pkg::REG_FPP:      fpp_reg = cfg_data[4:0];
					amrpk_pkg::REG_NO_DATA:  no_data_reg = cfg_data[3:0];
					amrpk_pkg::REG_SID:      sid_reg = cfg_data[3:0];
					amrpk_pkg::REG_SPF:      spf_reg = cfg_data[9:0];
					amrpk_pkg::REG_WIDEBAND: wb_reg = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				take_request(command, toc);
			if (out_valid && !out_stall)
				check_header();
		end
		pending <= expected_headers.size();
	end

endmodule

// ===== sim/amr_rtp_payload_header_packetizer_tb.sv =====
`timescale 1ns / 1ps

module amr_rtp_payload_header_packetizer_tb;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 30;
	localparam int HOLD_CYCLES   = 120;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 15;
	localparam int HOLD_PHASE    = 3;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_we = 1'b0;
	logic [amrpk_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [amrpk_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic                             command = amrpk_tb_pkg::CMD_ADD;
	logic [7:0]                       toc = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic [7:0]                       header_byte;
	logic                             is_last;
	logic [4:0]                       frame_count;
	logic [9:0]                       packet_length;
	logic [31:0]                      timestamp_increment;
	logic [31:0]                      time_delta;
	logic [31:0]                      frame_total;
	logic [31:0]                      packet_total;
	logic [31:0]                      payload_total;
	int                               errors;
	int                               pending;

	// Traffic shaping
	logic quiet = 1'b0;
	logic hold_on = 1'b0;
	logic send_jitter = 1'b1;
	logic stall_jitter = 1'b1;
	int   hold_count = 0;
	int   stall_left = 0;
	int   cycle_count = 0;

	// Register values the stimulus aims at
	logic [3:0] cur_no_data = amrpk_pkg::NO_DATA_RST;
	logic [3:0] cur_sid = amrpk_pkg::SID_RST;
	logic       cur_wb = 1'b0;

	always #1 clk = ~clk;

	amr_rtp_payload_header_packetizer dut (.*);

	amrpk_header_checker checker_i (.*);

	// Receiver: one long hold-off on request, short random bursts otherwise
	always @(posedge clk) begin
		if (hold_on && hold_count < HOLD_CYCLES) begin
			out_stall <= 1'b1;
			hold_count <= hold_count + 1;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!quiet && stall_jitter && $urandom_range(0, 4) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 3);
		end else begin
			out_stall <= 1'b0;
		end
		if ($urandom_range(0, 63) == 0)
			stall_jitter <= ~stall_jitter;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** amr_rtp_payload_header_packetizer: FAILED **");
			$finish;
		end
	end

	function automatic logic [7:0] toc_of(input logic [3:0] ftype);
		return {1'($urandom), ftype, 3'($urandom)};
	endfunction

	// Offer one request and hold it until taken
	task automatic send_req(input logic cmd, input logic [7:0] tocb);
		if ($urandom_range(0, 19) == 0)
			send_jitter = ~send_jitter;
		if (!quiet && send_jitter && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		toc <= tocb;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Stop offering, wait for every expected byte, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all registers; unused data bits carry noise
	task automatic program_regs(input logic [4:0] fpp, input logic [3:0] nd,
			input logic [3:0] sid, input logic [9:0] spf, input logic wb);
		cfg_we <= 1'b1;
		cfg_index <= amrpk_pkg::REG_FPP;
		cfg_data <= {5'($urandom), fpp};
		@(posedge clk);
		cfg_index <= amrpk_pkg::REG_NO_DATA;
		cfg_data <= {6'($urandom), nd};
		@(posedge clk);
		cfg_index <= amrpk_pkg::REG_SID;
		cfg_data <= {6'($urandom), sid};
		@(posedge clk);
		cfg_index <= amrpk_pkg::REG_SPF;
		cfg_data <= spf;
		@(posedge clk);
		cfg_index <= amrpk_pkg::REG_WIDEBAND;
		cfg_data <= {9'($urandom), wb};
		@(posedge clk);
		cfg_index <= amrpk_tb_pkg::REG_UNUSED;
		cfg_data <= 10'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_no_data = nd;
		cur_sid = sid;
		cur_wb = wb;
	endtask

	initial begin
		logic [4:0] fpp;
		logic [3:0] nd;
		logic [3:0] sid;
		logic [9:0] spf;
		logic       wb;
		logic [3:0] ftype;
		int         pick;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: flush and no-data with nothing open, one-frame packet
		send_req(amrpk_tb_pkg::CMD_FLUSH, 8'h00);
		send_req(amrpk_tb_pkg::CMD_ADD, 8'hFF);
		send_req(amrpk_tb_pkg::CMD_ADD, 8'h00);

		// Full wideband packet over every stored type
		drain();
		program_regs(5'd16, 4'd15, 4'd9, 10'd1023, 1'b1);
		for (int i = 0; i < 16; i++) begin
			ftype = (i < 9) ? 4'(i) : (i < 14) ? 4'(i + 1) : (i == 14) ? 4'd0 : 4'd7;
			send_req(amrpk_tb_pkg::CMD_ADD, toc_of(ftype));
		end

		// SID closes, no-data closes, flush closes
		send_req(amrpk_tb_pkg::CMD_ADD, {1'b0, 4'd9, 3'b111});
		send_req(amrpk_tb_pkg::CMD_ADD, toc_of(4'd3));
		send_req(amrpk_tb_pkg::CMD_ADD, toc_of(4'd15));
		send_req(amrpk_tb_pkg::CMD_ADD, toc_of(4'd2));
		send_req(amrpk_tb_pkg::CMD_FLUSH, 8'($urandom));

		// Packet size lowered under an open packet
		send_req(amrpk_tb_pkg::CMD_ADD, toc_of(4'd1));
		send_req(amrpk_tb_pkg::CMD_ADD, toc_of(4'd4));
		drain();
		program_regs(5'd2, 4'd15, 4'd9, 10'd1, 1'b0);
		send_req(amrpk_tb_pkg::CMD_ADD, toc_of(4'd5));

		// Size zero acts as one; no-data and SID share a code
		drain();
		program_regs(5'd0, 4'd6, 4'd6, 10'd160, 1'b0);
		send_req(amrpk_tb_pkg::CMD_ADD, toc_of(4'd6));
		send_req(amrpk_tb_pkg::CMD_ADD, toc_of(4'd0));

		// Random phases, each with fresh settings
		for (int p = 0; p < PHASES; p++) begin
			wb = (p == 1) ? 1'b1 : 1'($urandom);
			case ($urandom_range(0, 3))
				0:       fpp = 5'd1;
				1:       fpp = 5'd16;
				default: fpp = 5'($urandom_range(1, 16));
			endcase
			if (p == 1)
				fpp = 5'($urandom_range(17, 31));
			else if (p == 2)
				fpp = 5'd0;
			nd = ($urandom_range(0, 2) != 0) ? 4'd15 : 4'($urandom);
			sid = ($urandom_range(0, 2) != 0) ? (wb ? 4'd9 : 4'd8) : 4'($urandom);
			if (p == 1) begin
				nd = 4'd0;
				sid = 4'd15;
			end
			case ($urandom_range(0, 3))
				0:       spf = 10'd1;
				1:       spf = 10'd1023;
				2:       spf = wb ? 10'd320 : 10'd160;
				default: spf = 10'($urandom_range(1, 1023));
			endcase
			drain();
			program_regs(fpp, nd, sid, spf, wb);
			if (p == PHASES - 1)
				quiet <= 1'b1;

			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == HOLD_PHASE && i == 4)
					hold_on <= 1'b1;
				pick = $urandom_range(0, 99);
				if (pick < 8)
					send_req(amrpk_tb_pkg::CMD_FLUSH, 8'($urandom));
				else if (pick < 16)
					send_req(amrpk_tb_pkg::CMD_ADD, toc_of(cur_no_data));
				else if (pick < 24)
					send_req(amrpk_tb_pkg::CMD_ADD, toc_of(cur_sid));
				else if (pick < 32)
					send_req(amrpk_tb_pkg::CMD_ADD, toc_of(4'($urandom)));
				else
					send_req(amrpk_tb_pkg::CMD_ADD,
						toc_of(4'($urandom_range(0, cur_wb ? 8 : 7))));
			end
		end

		drain();
		if (errors == 0)
			$display("** amr_rtp_payload_header_packetizer: PASSED **");
		else
			$display("** amr_rtp_payload_header_packetizer: FAILED **");
		$finish;
	end

endmodule
